[sv/utf8_text_to_tile_writer_defines.svh]
// Assertion macros for the text-to-tile writer checker
`ifndef UTF8_TEXT_TO_TILE_WRITER_DEFINES_SVH
`define UTF8_TEXT_TO_TILE_WRITER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UTT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tile writer check failed");

// next-cycle implication, sampled on clk, off during reset
`define UTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tile writer check failed");

`endif

[sv/utt_pkg.sv]
// Shared types, constants and the CP866 pair mapping for the text-to-tile writer
package utt_pkg;

	localparam int GRID_COLS_DEF = 40;
	localparam int GRID_ROWS_DEF = 30;

	localparam int CURSOR_W = 10;

	localparam logic [7:0] BYTE_NL    = 8'h0A;
	localparam logic [7:0] BYTE_LEAD  = 8'h80;
	localparam logic [7:0] LEAD_D0    = 8'hD0;
	localparam logic [7:0] LEAD_D1    = 8'hD1;
	localparam logic [7:0] CODE_UNMAP = 8'h3F;
	localparam logic [7:0] CODE_YO_UC = 8'hF0;
	localparam logic [7:0] CODE_YO_LC = 8'hF1;
	localparam logic [7:0] BASE_UC    = 8'h80;
	localparam logic [7:0] BASE_LC_A  = 8'hA0;
	localparam logic [7:0] BASE_LC_R  = 8'hE0;

	typedef struct packed {
		logic        [7:0] text_byte;
		logic              first;
		logic signed [7:0] start_col;
		logic signed [7:0] start_row;
		logic        [7:0] color;
	} item_t;

	typedef struct packed {
		logic       emit;
		logic [5:0] col;
		logic [4:0] row;
		logic [7:0] code;
		logic [7:0] color;
	} tile_t;

	function automatic logic [7:0] map_pair(input logic [7:0] c, input logic [7:0] c2);
		logic [7:0] code;
		code = CODE_UNMAP;
		if (c == LEAD_D0) begin
			if (c2 inside {[8'h90:8'hAF]})
				code = BASE_UC + (c2 - 8'h90);
			else if (c2 inside {[8'hB0:8'hBF]})
				code = BASE_LC_A + (c2 - 8'hB0);
			else if (c2 == 8'h81)
				code = CODE_YO_UC;
		end else if (c == LEAD_D1) begin
			if (c2 inside {[8'h80:8'h8F]})
				code = BASE_LC_R + (c2 - 8'h80);
			else if (c2 == 8'h91)
				code = CODE_YO_LC;
		end
		return code;
	endfunction

endpackage

[sv/utt_cursor.sv]
// Cursor, origin, colour and lead-byte state with the per-byte tile decision
module utt_cursor #(
	parameter int GRID_COLS = utt_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = utt_pkg::GRID_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic          utf8_mode,
	input  utt_pkg::item_t item,
	output utt_pkg::tile_t tile
);
	import utt_pkg::*;

	localparam logic signed [CURSOR_W-1:0] COLS_S = CURSOR_W'(GRID_COLS);
	localparam logic signed [CURSOR_W-1:0] ROWS_S = CURSOR_W'(GRID_ROWS);
	localparam logic signed [CURSOR_W-1:0] ONE_S  = CURSOR_W'(1);

	logic signed [CURSOR_W-1:0] col_q, row_q, org_q;
	logic        [7:0]          color_q, lead_q;
	logic                       pend_q;

	logic signed [CURSOR_W-1:0] e_col, e_row, e_org, col_inc;
	logic signed [CURSOR_W-1:0] n_col, n_row;
	logic        [7:0]          e_color, n_lead, code;
	logic                       e_pend, n_pend, on_grid, row_ok, put, advance;

	always_comb begin
		if (item.first) begin
			e_org   = {{(CURSOR_W-8){item.start_col[7]}}, item.start_col};
			e_col   = {{(CURSOR_W-8){item.start_col[7]}}, item.start_col};
			e_row   = {{(CURSOR_W-8){item.start_row[7]}}, item.start_row};
			e_color = item.color;
			e_pend  = 1'b0;
		end else begin
			e_org   = org_q;
			e_col   = col_q;
			e_row   = row_q;
			e_color = color_q;
			e_pend  = pend_q;
		end
		on_grid = (e_col >= 0) && (e_col < COLS_S) && (e_row >= 0) && (e_row < ROWS_S);
		row_ok  = e_row < ROWS_S;
		col_inc = e_col + ONE_S;

		n_col   = e_col;
		n_row   = e_row;
		n_pend  = e_pend;
		n_lead  = lead_q;
		code    = item.text_byte;
		put     = 1'b0;
		advance = 1'b0;

		if (!utf8_mode) begin
			n_pend = 1'b0;
			if (row_ok) begin
				if (item.text_byte == BYTE_NL) begin
					n_col = e_org;
					n_row = e_row + ONE_S;
				end else if (on_grid) begin
					put   = 1'b1;
					n_col = col_inc;
				end
			end
		end else if (row_ok) begin
			if (e_pend) begin
				code    = map_pair(lead_q, item.text_byte);
				n_pend  = 1'b0;
				advance = 1'b1;
			end else if (item.text_byte == BYTE_NL) begin
				n_col = e_org;
				n_row = e_row + ONE_S;
			end else if (item.text_byte >= BYTE_LEAD) begin
				n_lead = item.text_byte;
				n_pend = 1'b1;
			end else begin
				advance = 1'b1;
			end
			if (advance) begin
				put = on_grid;
				if (col_inc >= COLS_S) begin
					n_col = e_org;
					n_row = e_row + ONE_S;
				end else begin
					n_col = col_inc;
				end
			end
		end

		tile.emit  = go && put;
		tile.col   = e_col[5:0];
		tile.row   = e_row[4:0];
		tile.code  = code;
		tile.color = e_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			org_q   <= '0;
			color_q <= '0;
			lead_q  <= '0;
			pend_q  <= 1'b0;
		end else if (go) begin
			col_q   <= n_col;
			row_q   <= n_row;
			org_q   <= e_org;
			color_q <= e_color;
			lead_q  <= n_lead;
			pend_q  <= n_pend;
		end
	end

endmodule

[sv/utf8_text_to_tile_writer.sv]
// Top level of the text-to-tile writer: input stage, cursor logic, result register
//
//   channel | direction | handshake              | payload
//   text    | in        | text_valid/text_stall  | text_byte first start_col start_row color
//   tile    | out       | tile_valid/tile_stall  | tile_col tile_row tile_code tile_color
//   cfg     | in        | cfg_valid/cfg_ready    | utf8_mode
//
// One byte is taken every cycle while text_stall is low; its tile, if any, is registered after the input stage.
// The cursor update (one add and compare on a 10-bit cursor) sets the cycle.
// Reset selects UTF-8 mode and clears cursor, origin and colour, no lead byte held.
// A stalled tile holds the input stage, and text_stall rises only then.
module utf8_text_to_tile_writer #(
	parameter int GRID_COLS = utt_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = utt_pkg::GRID_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	output logic              text_stall,
	input  logic        [7:0] text_byte,
	input  logic              first,
	input  logic signed [7:0] start_col,
	input  logic signed [7:0] start_row,
	input  logic        [7:0] color,
	output logic              tile_valid,
	input  logic              tile_stall,
	output logic        [5:0] tile_col,
	output logic        [4:0] tile_row,
	output logic        [7:0] tile_code,
	output logic        [7:0] tile_color,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              utf8_mode
);
	import utt_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	logic  mode_q;
	logic  tile_valid_q;
	tile_t tile_q;
	tile_t tile_d;
	logic  adv, text_take;

	assign adv       = valid_s1 && (!tile_valid_q || !tile_stall);
	assign text_stall = valid_s1 && !adv;
	assign text_take = text_valid && !text_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= utf8_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_take) begin
			item_s1 <= '{text_byte: text_byte, first: first, start_col: start_col,
				start_row: start_row, color: color};
		end
	end

	utt_cursor #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (adv),
		.utf8_mode(mode_q),
		.item     (item_s1),
		.tile     (tile_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_valid_q <= 1'b0;
		end else if (adv && tile_d.emit) begin
			tile_valid_q <= 1'b1;
		end else if (!tile_stall) begin
			tile_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tile_d.emit) begin
			tile_q <= tile_d;
		end
	end

	assign tile_valid = tile_valid_q;
	assign tile_col   = tile_q.col;
	assign tile_row   = tile_q.row;
	assign tile_code  = tile_q.code;
	assign tile_color = tile_q.color;

endmodule

[sv/utt_chk.sv]
// Port-level checker for the text-to-tile writer and its bind
`include "utf8_text_to_tile_writer_defines.svh"

module utt_chk #(
	parameter int GRID_COLS = utt_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = utt_pkg::GRID_ROWS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              text_stall,
	input logic              tile_valid,
	input logic              tile_stall,
	input logic        [5:0] tile_col,
	input logic        [4:0] tile_row,
	input logic        [7:0] tile_code,
	input logic        [7:0] tile_color,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	// hold a stalled tile transfer
	`UTT_ASSERT_NEXT(a_tile_hold, tile_valid && tile_stall, tile_valid && $stable(tile_col) && $stable(tile_row) && $stable(tile_code) && $stable(tile_color))

	`UTT_ASSERT_NOW(a_tile_on_grid, tile_valid, (GRID_COLS > 64 || int'(tile_col) < GRID_COLS) && (GRID_ROWS > 32 || int'(tile_row) < GRID_ROWS))

	// input back-pressure only while a tile waits
	`UTT_ASSERT_NOW(a_stall_needs_tile, text_stall, tile_valid && tile_stall)

	`UTT_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind utf8_text_to_tile_writer utt_chk #(
	.GRID_COLS(GRID_COLS),
	.GRID_ROWS(GRID_ROWS)
) u_utt_chk (.*);

[test/tb_utf8_text_to_tile_writer.sv]
// Self-checking testbench for the text-to-tile writer: scripted and random text against a predictor
`timescale 1ns / 1ps

module tb_utf8_text_to_tile_writer;
	import utt_pkg::*;

	localparam int  GRID_W      = GRID_COLS_DEF;
	localparam int  GRID_H      = GRID_ROWS_DEF;
	localparam bit  MODE_RAW    = 1'b0;
	localparam bit  MODE_UTF8   = 1'b1;
	localparam int  IDLE_PCT    = 18;
	localparam int  SETTLE      = 8;
	localparam int  PHASE_BYTES = 270;
	localparam int  CYCLE_LIMIT = 400000;
	localparam logic signed [CURSOR_W-1:0] STEP = CURSOR_W'(1);

	typedef struct packed {
		logic [5:0] col;
		logic [4:0] row;
		logic [7:0] code;
		logic [7:0] color;
	} tile_write_t;

	typedef struct packed {
		bit                mode;
		logic        [7:0] b;
		bit                first;
		logic signed [7:0] scol;
		logic signed [7:0] srow;
		logic        [7:0] colr;
		bit                chk;
		tile_write_t       want;
	} script_row_t;

	logic              clk;
	logic              arst_n     = 1'b0;
	logic              text_valid = 1'b0;
	logic              text_stall;
	logic        [7:0] text_byte  = 8'h00;
	logic              first      = 1'b0;
	logic signed [7:0] start_col  = 8'sd0;
	logic signed [7:0] start_row  = 8'sd0;
	logic        [7:0] color      = 8'h00;
	logic              tile_valid;
	logic              tile_stall = 1'b0;
	logic        [5:0] tile_col;
	logic        [4:0] tile_row;
	logic        [7:0] tile_code;
	logic        [7:0] tile_color;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic              utf8_mode  = MODE_UTF8;

	bit                scripted_check = 1'b0;
	tile_write_t       scripted_tile  = '0;
	bit                steady         = 1'b0;

	tile_write_t       pending_tiles[$];
	script_row_t       script[29];
	int                bytes_sent  = 0;
	int                tiles_seen  = 0;
	int                mismatches  = 0;
	int                mode_writes = 0;
	int                cycles      = 0;

	bit                       mode_utf8 = MODE_UTF8;
	logic signed [CURSOR_W-1:0] cur_col = '0;
	logic signed [CURSOR_W-1:0] cur_row = '0;
	logic signed [CURSOR_W-1:0] org_col = '0;
	logic        [7:0]          pen_color = '0;
	logic        [7:0]          lead_b = '0;
	bit                         lead_held = 1'b0;

	utf8_text_to_tile_writer #(
		.GRID_COLS(GRID_W),
		.GRID_ROWS(GRID_H)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte (text_byte),
		.first     (first),
		.start_col (start_col),
		.start_row (start_row),
		.color     (color),
		.tile_valid(tile_valid),
		.tile_stall(tile_stall),
		.tile_col  (tile_col),
		.tile_row  (tile_row),
		.tile_code (tile_code),
		.tile_color(tile_color),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.utf8_mode (utf8_mode)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] cp866_of(input logic [7:0] lead, input logic [7:0] trail);
		logic [7:0] res;
		res = CODE_UNMAP;
		if (lead == LEAD_D0 && trail >= 8'h90 && trail <= 8'hAF)
			res = BASE_UC + (trail - 8'h90);
		else if (lead == LEAD_D0 && trail >= 8'hB0 && trail <= 8'hBF)
			res = BASE_LC_A + (trail - 8'hB0);
		else if (lead == LEAD_D1 && trail >= 8'h80 && trail <= 8'h8F)
			res = BASE_LC_R + (trail - 8'h80);
		else if (lead == LEAD_D0 && trail == 8'h81)
			res = CODE_YO_UC;
		else if (lead == LEAD_D1 && trail == 8'h91)
			res = CODE_YO_LC;
		return res;
	endfunction

	function automatic bit cursor_visible();
		return cur_col >= 0 && cur_col < GRID_W && cur_row >= 0 && cur_row < GRID_H;
	endfunction

	function automatic bit render_byte(input item_t it, output tile_write_t t);
		logic [7:0] code;
		bit         hit;
		hit = 1'b0;
		t = '0;
		if (it.first) begin
			org_col = CURSOR_W'(it.start_col);
			cur_col = org_col;
			cur_row = CURSOR_W'(it.start_row);
			pen_color = it.color;
			lead_held = 1'b0;
		end
		if (cur_row >= GRID_H) begin
			if (!mode_utf8)
				lead_held = 1'b0;
			return 1'b0;
		end
		if (!mode_utf8) begin
			lead_held = 1'b0;
			if (it.text_byte == BYTE_NL) begin
				cur_col = org_col;
				cur_row = cur_row + STEP;
				return 1'b0;
			end
			if (cursor_visible()) begin
				t = '{cur_col[5:0], cur_row[4:0], it.text_byte, pen_color};
				cur_col = cur_col + STEP;
				hit = 1'b1;
			end
			return hit;
		end
		if (lead_held) begin
			code = cp866_of(lead_b, it.text_byte);
			lead_held = 1'b0;
		end else if (it.text_byte == BYTE_NL) begin
			cur_col = org_col;
			cur_row = cur_row + STEP;
			return 1'b0;
		end else if (it.text_byte >= BYTE_LEAD) begin
			lead_b = it.text_byte;
			lead_held = 1'b1;
			return 1'b0;
		end else begin
			code = it.text_byte;
		end
		if (cursor_visible()) begin
			t = '{cur_col[5:0], cur_row[4:0], code, pen_color};
			hit = 1'b1;
		end
		cur_col = cur_col + STEP;
		if (cur_col >= GRID_W) begin
			cur_col = org_col;
			cur_row = cur_row + STEP;
		end
		return hit;
	endfunction

	always @(posedge clk) begin : watch
		tile_write_t t;
		tile_write_t want;
		bit          hit;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				mode_utf8 = utf8_mode;
			if (text_valid && !text_stall) begin
				hit = render_byte({text_byte, first, start_col, start_row, color}, t);
				if (scripted_check) begin
					t = scripted_tile;
					hit = 1'b1;
				end
				if (hit)
					pending_tiles.push_back(t);
			end
			if (tile_valid && !tile_stall) begin
				tiles_seen++;
				if (pending_tiles.size() == 0) begin
					mismatches++;
					$error("unexpected tile: col %0d row %0d code %0h colour %0h",
						tile_col, tile_row, tile_code, tile_color);
				end else begin
					want = pending_tiles.pop_front();
					if (tile_col !== want.col) begin
						mismatches++;
						$error("tile_col: expected %0d, got %0d", want.col, tile_col);
					end
					if (tile_row !== want.row) begin
						mismatches++;
						$error("tile_row: expected %0d, got %0d", want.row, tile_row);
					end
					if (tile_code !== want.code) begin
						mismatches++;
						$error("tile_code: expected %0h, got %0h", want.code, tile_code);
					end
					if (tile_color !== want.color) begin
						mismatches++;
						$error("tile_color: expected %0h, got %0h", want.color, tile_color);
					end
				end
			end
		end
	end

	always @(posedge clk)
		tile_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic put_byte(input item_t it, input bit chk, input tile_write_t want);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid     <= 1'b1;
		text_byte      <= it.text_byte;
		first          <= it.first;
		start_col      <= it.start_col;
		start_row      <= it.start_row;
		color          <= it.color;
		scripted_check <= chk;
		scripted_tile  <= want;
		do @(posedge clk); while (text_stall);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		text_valid <= 1'b0;
		@(posedge clk);
		while (pending_tiles.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(input bit m);
		wait_idle();
		cfg_valid <= 1'b1;
		utf8_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_writes++;
	endtask

	function automatic item_t text_item(input logic [7:0] b, input bit is_first);
		item_t it;
		it.text_byte = b;
		it.first = is_first;
		it.start_col = 8'($urandom);
		it.start_row = 8'($urandom);
		it.color = 8'($urandom);
		if (is_first && $urandom_range(9) < 8) begin
			it.start_col = 8'($urandom_range(45) - 3);
			it.start_row = 8'($urandom_range(32) - 2);
		end
		return it;
	endfunction

	task automatic run_string();
		logic [7:0] seq[$];
		int         len;
		int         kind;
		len = $urandom_range(1, 48);
		while (seq.size() < len) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (kind < 55) begin
				case ($urandom_range(3))
					0: begin
						seq.push_back(LEAD_D0);
						seq.push_back(8'(8'h90 + $urandom_range(47)));
					end
					1: begin
						seq.push_back(LEAD_D0);
						seq.push_back(8'h81);
					end
					2: begin
						seq.push_back(LEAD_D1);
						seq.push_back(8'(8'h80 + $urandom_range(15)));
					end
					default: begin
						seq.push_back(LEAD_D1);
						seq.push_back(8'h91);
					end
				endcase
			end else if (kind < 63) begin
				seq.push_back(BYTE_NL);
			end else if (kind < 73) begin
				seq.push_back(8'($urandom_range(8'h80, 8'hFF)));
				seq.push_back(8'($urandom_range(8'h01, 8'hFF)));
			end else if (kind < 85) begin
				seq.push_back(8'($urandom_range(8'h01, 8'hFF)));
			end else begin
				seq.push_back($urandom_range(1) ? LEAD_D1 : LEAD_D0);
				seq.push_back(8'($urandom_range(8'h01, 8'hFF)));
			end
		end
		foreach (seq[i])
			put_byte(text_item(seq[i], i == 0), 1'b0, '0);
	endtask

	initial begin : stimulus
		bit mode_now;
		script = '{
			'{MODE_UTF8, 8'h41,   0,    0,    0, 8'h00, 1, '{ 0,  0, 8'h41, 8'h00}},
			'{MODE_UTF8, 8'h7F,   1,   39,   29, 8'hFF, 1, '{39, 29, 8'h7F, 8'hFF}},
			'{MODE_UTF8, 8'h42,   0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'h78,   1, -128, -128, 8'h55, 0, '0},
			'{MODE_UTF8, LEAD_D0, 1,    0,    0, 8'h12, 0, '0},
			'{MODE_UTF8, 8'h90,   0,    0,    0, 8'h00, 1, '{ 0,  0, 8'h80, 8'h12}},
			'{MODE_UTF8, LEAD_D0, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'hAF,   0,    0,    0, 8'h00, 1, '{ 1,  0, 8'h9F, 8'h12}},
			'{MODE_UTF8, LEAD_D0, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'hBF,   0,    0,    0, 8'h00, 1, '{ 2,  0, 8'hAF, 8'h12}},
			'{MODE_UTF8, LEAD_D1, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'h8F,   0,    0,    0, 8'h00, 1, '{ 3,  0, 8'hEF, 8'h12}},
			'{MODE_UTF8, LEAD_D0, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'h81,   0,    0,    0, 8'h00, 1, '{ 4,  0, CODE_YO_UC, 8'h12}},
			'{MODE_UTF8, LEAD_D1, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'h91,   0,    0,    0, 8'h00, 1, '{ 5,  0, CODE_YO_LC, 8'h12}},
			'{MODE_UTF8, 8'hFF,   0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'hFF,   0,    0,    0, 8'h00, 1, '{ 6,  0, CODE_UNMAP, 8'h12}},
			'{MODE_UTF8, LEAD_D0, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, BYTE_NL, 0,    0,    0, 8'h00, 1, '{ 7,  0, CODE_UNMAP, 8'h12}},
			'{MODE_UTF8, BYTE_NL, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, LEAD_D1, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_RAW,  LEAD_D0, 0,    0,    0, 8'h00, 1, '{ 0,  1, LEAD_D0, 8'h12}},
			'{MODE_RAW,  8'hFF,   1,   38,    0, 8'h0F, 1, '{38,  0, 8'hFF, 8'h0F}},
			'{MODE_RAW,  8'h01,   0,    0,    0, 8'h00, 1, '{39,  0, 8'h01, 8'h0F}},
			'{MODE_RAW,  8'h41,   0,    0,    0, 8'h00, 0, '0},
			'{MODE_RAW,  BYTE_NL, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, LEAD_D1, 0,    0,    0, 8'h00, 0, '0},
			'{MODE_UTF8, 8'h00,   1,  127,    5, 8'hAA, 0, '0}
		};
		mode_now = MODE_UTF8;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].mode != mode_now) begin
				set_mode(script[i].mode);
				mode_now = script[i].mode;
			end
			put_byte({script[i].b, script[i].first, script[i].scol, script[i].srow,
				script[i].colr}, script[i].chk, script[i].want);
		end

		for (int p = 0; p < 5; p++) begin
			set_mode(p % 2 == 0 ? MODE_UTF8 : MODE_RAW);
			steady = (p == 2);
			for (int s = 0; bytes_sent < $size(script) + (p + 1) * PHASE_BYTES; s++) begin
				// hold the text side until every tile so far has drained
				if (p == 3 && s == 6)
					wait_idle();
				run_string();
			end
			steady = 1'b0;
		end
		wait_idle();

		$display("Covered %0d text bytes over %0d mode writes in both modes", bytes_sent,
			mode_writes);
		$display("Compared %0d tile writes, %0d field mismatches", tiles_seen, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
